// ===== rtl/wds_pkg.sv =====
// Shared types, constants and helpers for the windowed delta statistics block.
package wds_pkg;

    localparam int ACTION_COUNT_DEF = 8;
    localparam int WINDOW_MAX_DEF   = 16;

    localparam int ACTION_W = 3;
    localparam int DELTA_W  = 32;
    localparam int AVG_W    = 32;
    localparam int MEAN_W   = 32;
    localparam int STD_W    = 31;
    localparam int DEC_W    = 2;
    localparam int CNT_W    = 16;
    localparam int SSQ_W    = 64;
    localparam int WL_W     = 5;
    localparam int TF_W     = 16;
    localparam int STEP_W   = 7;
    localparam int DIVR_W   = 16;

    localparam logic [WL_W-1:0] WL_RESET = WL_W'(8);
    localparam logic [TF_W-1:0] TF_RESET = TF_W'(256);

    localparam logic [DEC_W-1:0] DEC_KEEP  = 2'd0;
    localparam logic [DEC_W-1:0] DEC_RAISE = 2'd1;
    localparam logic [DEC_W-1:0] DEC_LOWER = 2'd2;

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_THRESHOLD     = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDSTAT,
        S_RDWIN,
        S_AVG_GO,
        S_AVG_WAIT,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DEC,
        S_WB,
        S_OUT
    } state_t;

    // action index wrap for a 3-bit value, at most eight subtract steps
    function automatic logic [6:0] wrap_index(logic [ACTION_W-1:0] v, logic [6:0] n);
        logic [6:0] r;
        r = {4'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/wds_if.sv =====
// Request and response channel interfaces.
interface wds_req_if import wds_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [ACTION_W-1:0] action_index;
    logic signed [DELTA_W-1:0]  delta_value;

    modport source (output valid, output action_index, output delta_value, input ready);
    modport sink (input valid, input action_index, input delta_value, output ready);
endinterface

interface wds_rsp_if import wds_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [AVG_W-1:0]   window_average;
    logic                      window_was_empty;
    logic signed [MEAN_W-1:0]  running_mean;
    logic        [STD_W-1:0]   std_deviation;
    logic        [DEC_W-1:0]   rate_decision;

    modport source (output valid, output window_average, output window_was_empty,
                    output running_mean, output std_deviation, output rate_decision,
                    input ready);
    modport sink (input valid, input window_average, input window_was_empty,
                  input running_mean, input std_deviation, input rate_decision,
                  output ready);
endinterface

// ===== rtl/windowed_delta_statistics.sv =====
// Windowed delta statistics: per-action window average, running mean and deviation.
//
// Input channel req carries an action index and a signed Q16.16 error value.
// Output channel rsp returns one result per accepted transaction: the average
// of the values held before the push, an empty flag, the running mean of
// averages, the sample standard deviation and a raise/lower/keep decision.
// Configuration goes through the APB port: window_length at 0x0 and
// threshold_factor at 0x4; write them only while the block is idle.
// One item is worked at a time. The work uses the shared restoring divider
// (SUM_W steps for the average, 33 for the mean update, 64 for the variance)
// and the 32-step square root, each started in a GO state and awaited in a
// WAIT state. An empty window skips the average, the mean and the
// sum-of-squares update; a count of one or less skips the variance and root.
// Per-action state lives in a statistics RAM and a window RAM, read, updated
// and written back once.
// A new request is accepted while a finished result still waits in the
// output register; the result of that item is held until rsp is taken.
// Reset clears the per-action valid flags, so every action starts with zero
// statistics; the window RAM needs no clearing.
module windowed_delta_statistics import wds_pkg::*; #(
    parameter int ACTION_COUNT = ACTION_COUNT_DEF,
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    wds_req_if.sink     req,
    wds_rsp_if.source   rsp
);
    localparam int AW     = ACTION_COUNT > 1 ? $clog2(ACTION_COUNT) : 1;
    localparam int PW     = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
    localparam int FW     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = DELTA_W + FW;
    localparam int STAT_W = PW + FW + SUM_W + CNT_W + MEAN_W + SSQ_W;
    localparam logic [8:0] WM9 = 9'(WINDOW_MAX);

    // configuration registers
    logic [WL_W-1:0] wl_reg;
    logic [TF_W-1:0] tf_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WL_RESET;
            tf_reg <= TF_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WINDOW_LENGTH)
            begin
                wl_reg <= pwdata[WL_W-1:0];
            end
            else
            begin
                tf_reg <= pwdata[TF_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {27'b0, wl_reg} : {16'b0, tf_reg};

    // state and work registers
    state_t state_reg, state_next;

    logic [ACTION_COUNT-1:0]   valid_reg;
    logic [AW-1:0]             act_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [PW-1:0]             wp_reg;
    logic [FW-1:0]             f_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [SSQ_W-1:0]          ssq_reg;
    logic signed [DELTA_W-1:0] old_reg;
    logic signed [AVG_W-1:0]   avg_reg;
    logic signed [32:0]        d1_reg;
    logic signed [32:0]        d2_reg;
    logic [32:0]               m1_reg;
    logic [32:0]               m2_reg;
    logic [48:0]               plo_reg;
    logic [49:0]               phi_reg;
    logic [STD_W-1:0]          sd_reg;
    logic [DEC_W-1:0]          dec_reg;

    logic                      rsp_valid_reg;
    logic signed [AVG_W-1:0]   rsp_avg_reg;
    logic                      rsp_empty_reg;
    logic signed [MEAN_W-1:0]  rsp_mean_reg;
    logic [STD_W-1:0]          rsp_sd_reg;
    logic [DEC_W-1:0]          rsp_dec_reg;

    // memories
    logic              st_we, st_re;
    logic [AW-1:0]     st_raddr;
    logic [STAT_W-1:0] st_wdata, st_rdata;
    logic              win_we, win_re;
    logic [AW+PW-1:0]  win_raddr;
    logic [DELTA_W-1:0] win_rdata;

    wds_ram #(.WIDTH(STAT_W), .DEPTH(2 ** AW)) u_stat_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (act_reg),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    wds_ram #(.WIDTH(DELTA_W), .DEPTH(2 ** (AW + PW))) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr ({act_reg, wp_reg}),
        .wdata (delta_reg),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // shared divider and root
    div_ctl_t          div_ctl;
    logic [63:0]       div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic              div_done;
    logic [63:0]       div_q;
    logic              sq_start;
    logic              sq_done;
    logic [31:0]       sq_root;

    wds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    wds_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (div_q),
        .done     (sq_done),
        .root     (sq_root)
    );

    // datapath helpers
    logic [6:0]              act_wrap;
    logic [PW-1:0]           rd_wp;
    logic [FW-1:0]           rd_f;
    logic [FW:0]             oldest_w;
    logic [8:0]              len9;
    logic                    evict;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [AVG_W-1:0] avg_c;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [32:0]      q_signed;
    logic signed [33:0]      mean_sum;
    logic signed [32:0]      d2_c;
    logic [65:0]             prod;
    logic [66:0]             ssq_sum;
    logic signed [47:0]      lhs;
    logic signed [47:0]      rhs;
    logic                    same_sign;
    logic signed [SUM_W-1:0] sum_new;
    logic [PW:0]             wp_inc;

    assign act_wrap = wrap_index(req.action_index, 7'(ACTION_COUNT));
    assign rd_wp    = valid_reg[act_reg] ? st_rdata[STAT_W-1 -: PW] : '0;
    assign rd_f     = valid_reg[act_reg] ? st_rdata[STAT_W-PW-1 -: FW] : '0;
    // oldest held entry: write pointer minus fill, modulo the ring size
    assign oldest_w = ({1'b0, rd_wp} >= (FW+1)'(rd_f))
                    ? (FW+1)'({1'b0, rd_wp} - (FW+1)'(rd_f))
                    : (FW+1)'({1'b0, rd_wp} + (FW+1)'(WINDOW_MAX) - (FW+1)'(rd_f));

    assign len9  = (wl_reg == '0) ? 9'd1 : (({4'b0, wl_reg} > WM9) ? WM9 : {4'b0, wl_reg});
    assign evict = 9'(f_reg) >= len9;

    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign avg_c    = sum_reg[SUM_W-1] ? AVG_W'(-div_q[AVG_W-1:0]) : AVG_W'(div_q[AVG_W-1:0]);
    assign cnt_inc  = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign q_signed = d1_reg[32] ? -$signed(div_q[32:0]) : $signed(div_q[32:0]);
    assign mean_sum = 34'(mean_reg) + 34'(q_signed);
    assign d2_c     = 33'(avg_reg) - 33'(mean_reg);
    assign prod     = {17'b0, plo_reg} + {phi_reg, 16'b0};
    assign ssq_sum  = {3'b0, ssq_reg} + {1'b0, prod};
    assign lhs      = 48'(d2_reg) <<< 8;
    assign rhs      = $signed({1'b0, 47'(tf_reg * sd_reg)});
    assign same_sign = (avg_reg > 0 && delta_reg > 0) || (avg_reg < 0 && delta_reg < 0);
    assign sum_new  = sum_reg - (evict ? SUM_W'(old_reg) : SUM_W'(0)) + SUM_W'(delta_reg);
    assign wp_inc   = (PW+1)'(wp_reg) + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (req.valid) state_next = S_RDSTAT;
            S_RDSTAT:    state_next = S_RDWIN;
            S_RDWIN:     state_next = (f_reg == '0) ? S_VAR_GO : S_AVG_GO;
            S_AVG_GO:    state_next = S_AVG_WAIT;
            S_AVG_WAIT:  if (div_done) state_next = S_MEAN_GO;
            S_MEAN_GO:   state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: if (div_done) state_next = S_DIFF;
            S_DIFF:      state_next = S_MUL_LO;
            S_MUL_LO:    state_next = S_MUL_HI;
            S_MUL_HI:    state_next = S_ACC;
            S_ACC:       state_next = S_VAR_GO;
            S_VAR_GO:    state_next = (cnt_reg <= CNT_W'(1)) ? S_DEC : S_VAR_WAIT;
            S_VAR_WAIT:  if (div_done) state_next = S_SQRT_GO;
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sq_done) state_next = S_DEC;
            S_DEC:       state_next = S_WB;
            S_WB:        state_next = S_OUT;
            S_OUT:       if (!rsp_valid_reg || rsp.ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready     = 1'b0;
        st_re         = 1'b0;
        st_we         = 1'b0;
        win_re        = 1'b0;
        win_we        = 1'b0;
        sq_start      = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.steps = STEP_W'(SUM_W);
        div_dividend  = 64'(sum_mag);
        div_divisor   = DIVR_W'(f_reg);
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                st_re     = 1'b1;
            end
            S_RDSTAT:  win_re = 1'b1;
            S_AVG_GO:  div_ctl.start = 1'b1;
            S_MEAN_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(33);
                div_dividend  = 64'(d1_reg[32] ? 33'(-d1_reg) : 33'(d1_reg));
                div_divisor   = cnt_reg;
            end
            S_VAR_GO:
            begin
                div_ctl.start = cnt_reg > CNT_W'(1);
                div_ctl.steps = STEP_W'(64);
                div_dividend  = ssq_reg;
                div_divisor   = cnt_reg - 1'b1;
            end
            S_SQRT_GO: sq_start = 1'b1;
            S_WB:
            begin
                st_we  = 1'b1;
                win_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign st_raddr  = act_wrap[AW-1:0];
    assign win_raddr = {act_reg, oldest_w[PW-1:0]};
    assign st_wdata  = {(wp_inc == (PW+1)'(WINDOW_MAX)) ? PW'(0) : wp_inc[PW-1:0],
                        evict ? f_reg : f_reg + 1'b1,
                        sum_new, cnt_reg, mean_reg, ssq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WB)
            begin
                valid_reg[act_reg] <= 1'b1;
            end
            if (state_reg == S_OUT && state_next == S_IDLE)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                act_reg   <= act_wrap[AW-1:0];
                delta_reg <= req.delta_value;
            end
            S_RDSTAT:
            begin
                wp_reg <= rd_wp;
                f_reg  <= rd_f;
                if (valid_reg[act_reg])
                begin
                    sum_reg  <= st_rdata[STAT_W-PW-FW-1 -: SUM_W];
                    cnt_reg  <= st_rdata[CNT_W+MEAN_W+SSQ_W-1 -: CNT_W];
                    mean_reg <= st_rdata[MEAN_W+SSQ_W-1 -: MEAN_W];
                    ssq_reg  <= st_rdata[SSQ_W-1:0];
                end
                else
                begin
                    sum_reg  <= '0;
                    cnt_reg  <= '0;
                    mean_reg <= '0;
                    ssq_reg  <= '0;
                end
            end
            S_RDWIN:
            begin
                old_reg <= win_rdata;
                avg_reg <= '0;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_reg <= avg_c;
                    d1_reg  <= 33'(avg_c) - 33'(mean_reg);
                    cnt_reg <= cnt_inc;
                end
            end
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_reg <= mean_sum[MEAN_W-1:0];
                end
            end
            S_DIFF:
            begin
                d2_reg <= d2_c;
                m1_reg <= d1_reg[32] ? 33'(-d1_reg) : 33'(d1_reg);
                m2_reg <= d2_c[32] ? 33'(-d2_c) : 33'(d2_c);
            end
            S_MUL_LO: plo_reg <= m1_reg * m2_reg[15:0];
            S_MUL_HI: phi_reg <= m1_reg * m2_reg[32:16];
            S_ACC:    ssq_reg <= (ssq_sum[66:64] != 3'b0) ? {SSQ_W{1'b1}} : ssq_sum[63:0];
            S_VAR_GO: sd_reg <= '0;
            S_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    sd_reg <= sq_root[31] ? {STD_W{1'b1}} : sq_root[STD_W-1:0];
                end
            end
            S_DEC:
            begin
                if (!same_sign)
                begin
                    dec_reg <= DEC_LOWER;
                end
                else
                begin
                    dec_reg <= (lhs > rhs) ? DEC_RAISE : DEC_KEEP;
                end
            end
            S_WB:
            begin
                sum_reg <= sum_new;
            end
            S_OUT:
            begin
                if (state_next == S_IDLE)
                begin
                    rsp_avg_reg   <= avg_reg;
                    rsp_empty_reg <= (f_reg == '0);
                    rsp_mean_reg  <= mean_reg;
                    rsp_sd_reg    <= sd_reg;
                    rsp_dec_reg   <= dec_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.window_average   = rsp_avg_reg;
    assign rsp.window_was_empty = rsp_empty_reg;
    assign rsp.running_mean     = rsp_mean_reg;
    assign rsp.std_deviation    = rsp_sd_reg;
    assign rsp.rate_decision    = rsp_dec_reg;
endmodule

// ===== rtl/wds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/wds_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
module wds_div import wds_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl,
    input  logic [63:0]       dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [63:0]       quotient
);
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [63:0]       quo_reg;
    logic [DIVR_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[63]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend is left-aligned so only the significant steps are run
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= dividend << (STEP_W'(64) - ctl.steps);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIVR_W'(trial - {1'b0, dvs_reg}) : trial[DIVR_W-1:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/wds_sqrt.sv =====
// Iterative integer square root of a 64-bit value, two radicand bits per cycle.
module wds_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            root_reg <= '0;
            bit_reg  <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg    <= x_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[31:0];
endmodule
